// ===== rtl/grid_random_walk_coverage_top_defines.svh =====
// ----------------------------------------------------------------------------
// grid random walk coverage assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef GRID_RANDOM_WALK_COVERAGE_TOP_DEFINES_SVH
`define GRID_RANDOM_WALK_COVERAGE_TOP_DEFINES_SVH

// property checked only while out of reset
`define GRWC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked at every edge, reset included
`define GRWC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/grwc_pkg.sv =====
// ----------------------------------------------------------------------------
// grwc_pkg
// types, codes and constants shared by the grid random walk coverage block
// ----------------------------------------------------------------------------
package grwc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VISIT_W    = 16;
  localparam int MOVE_W     = 16;
  localparam int MIN_DIM    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [6:0]  GRID_ROWS_RST  = 7'd40;
  localparam logic [5:0]  GRID_COLS_RST  = 6'd20;
  localparam logic [5:0]  START_ROW_RST  = 6'd0;
  localparam logic [4:0]  START_COL_RST  = 5'd0;
  localparam logic [15:0] MOVE_LIMIT_RST = 16'd50000;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [VISIT_W-1:0] VISIT_MAX = {VISIT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OFF_GRID = 2'd1,
    ST_FINISHED = 2'd2,
    ST_ORDER    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2
  } step_t;

  typedef struct packed {
    logic       action;
    logic [2:0] direction;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [5:0]          bug_row;
    logic [4:0]          bug_col;
    logic [VISIT_W-1:0]  cell_visits;
    logic [MOVE_W-1:0]   move_count;
    logic [11:0]         cells_unvisited;
    logic                walk_done;
  } out_item_t;

  // decision of the walk stage handed to the count stage
  typedef struct packed {
    status_t status;
    logic    visit;    // cell count is bumped
    logic    start;    // item began the walk
    logic    started;  // walk running after this item
  } walk_ctl_t;

  // row offset per direction: -1 0 +1 +1 +1 0 -1 -1
  function automatic step_t row_step(input logic [2:0] dir);
    step_t s;
    case (dir)
      3'd0:    s = STEP_DEC;
      3'd1:    s = STEP_HOLD;
      3'd2:    s = STEP_INC;
      3'd3:    s = STEP_INC;
      3'd4:    s = STEP_INC;
      3'd5:    s = STEP_HOLD;
      3'd6:    s = STEP_DEC;
      3'd7:    s = STEP_DEC;
      default: s = STEP_HOLD;
    endcase
    return s;
  endfunction

  // column offset per direction: +1 +1 +1 0 -1 -1 -1 0
  function automatic step_t col_step(input logic [2:0] dir);
    step_t s;
    case (dir)
      3'd0:    s = STEP_INC;
      3'd1:    s = STEP_INC;
      3'd2:    s = STEP_INC;
      3'd3:    s = STEP_HOLD;
      3'd4:    s = STEP_DEC;
      3'd5:    s = STEP_DEC;
      3'd6:    s = STEP_DEC;
      3'd7:    s = STEP_HOLD;
      default: s = STEP_HOLD;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/grwc_visit_mem.sv =====
// ----------------------------------------------------------------------------
// grwc_visit_mem
// visit count memory, one write and one registered read port, zero sweep
// after reset
// ----------------------------------------------------------------------------
module grwc_visit_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [grwc_pkg::VISIT_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [grwc_pkg::VISIT_W-1:0] rdata,
  output logic                        clr_busy
);

  logic [grwc_pkg::VISIT_W-1:0] mem [DEPTH];
  logic [grwc_pkg::VISIT_W-1:0] rdata_r;
  logic                         clr_busy_r;
  logic [AW-1:0]                clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/grwc_walk.sv =====
// ----------------------------------------------------------------------------
// grwc_walk
// walk stage: position, grid size, move count and the per-item decision
// ----------------------------------------------------------------------------
module grwc_walk #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 32,
  parameter int RW       = 6,
  parameter int CW       = 5,
  parameter int NRW      = 7,
  parameter int NCW      = 6,
  parameter int AW       = 11,
  parameter int UW       = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  grwc_pkg::in_item_t          item,
  input  logic [6:0]                  grid_rows,
  input  logic [5:0]                  grid_cols,
  input  logic [5:0]                  start_row,
  input  logic [4:0]                  start_col,
  input  logic [grwc_pkg::MOVE_W-1:0] move_limit,
  input  logic [UW-1:0]               unv_eff,
  output logic [RW-1:0]               row_nxt,
  output logic [CW-1:0]               col_nxt,
  output logic [AW-1:0]               addr_nxt,
  output logic [grwc_pkg::MOVE_W-1:0] moves_nxt,
  output logic [UW-1:0]               prod_nxt,
  output grwc_pkg::walk_ctl_t         ctl_nxt
);

  logic [RW-1:0]               row_r;
  logic [CW-1:0]               col_r;
  logic [NRW-1:0]              used_rows_r, used_rows_nxt;
  logic [NCW-1:0]              used_cols_r, used_cols_nxt;
  logic                        started_r, started_nxt;
  logic [grwc_pkg::MOVE_W-1:0] moves_r;

  logic                        done_now;
  logic                        row_off, col_off;
  logic [RW-1:0]               row_try;
  logic [CW-1:0]               col_try;

  assign done_now = started_r && ((unv_eff == '0) || (moves_r >= move_limit));

  // candidate row after the step
  always_comb begin
    row_off = 1'b0;
    row_try = row_r;
    case (grwc_pkg::row_step(item.direction))
      grwc_pkg::STEP_INC: begin
        row_off = (NRW'(row_r) + NRW'(1)) >= used_rows_r;
        row_try = row_r + RW'(1);
      end
      grwc_pkg::STEP_DEC: begin
        row_off = (row_r == '0);
        row_try = row_r - RW'(1);
      end
      default: begin
        row_off = 1'b0;
        row_try = row_r;
      end
    endcase
  end

  // candidate column after the step
  always_comb begin
    col_off = 1'b0;
    col_try = col_r;
    case (grwc_pkg::col_step(item.direction))
      grwc_pkg::STEP_INC: begin
        col_off = (NCW'(col_r) + NCW'(1)) >= used_cols_r;
        col_try = col_r + CW'(1);
      end
      grwc_pkg::STEP_DEC: begin
        col_off = (col_r == '0);
        col_try = col_r - CW'(1);
      end
      default: begin
        col_off = 1'b0;
        col_try = col_r;
      end
    endcase
  end

  always_comb begin
    row_nxt        = row_r;
    col_nxt        = col_r;
    used_rows_nxt  = used_rows_r;
    used_cols_nxt  = used_cols_r;
    started_nxt    = started_r;
    moves_nxt      = moves_r;
    ctl_nxt.status = grwc_pkg::ST_OK;
    ctl_nxt.visit  = 1'b0;
    ctl_nxt.start  = 1'b0;
    case (item.action)
      grwc_pkg::ACT_START: begin
        if (started_r) begin
          ctl_nxt.status = grwc_pkg::ST_ORDER;
        end else begin
          // grid size saturates into its legal range
          if (32'(grid_rows) < grwc_pkg::MIN_DIM) begin
            used_rows_nxt = NRW'(grwc_pkg::MIN_DIM);
          end else if (32'(grid_rows) > MAX_ROWS) begin
            used_rows_nxt = NRW'(MAX_ROWS);
          end else begin
            used_rows_nxt = NRW'(grid_rows);
          end
          if (32'(grid_cols) < grwc_pkg::MIN_DIM) begin
            used_cols_nxt = NCW'(grwc_pkg::MIN_DIM);
          end else if (32'(grid_cols) > MAX_COLS) begin
            used_cols_nxt = NCW'(MAX_COLS);
          end else begin
            used_cols_nxt = NCW'(grid_cols);
          end
          // start cell saturates to the last row and column
          if (32'(start_row) >= 32'(used_rows_nxt)) begin
            row_nxt = RW'(32'(used_rows_nxt) - 32'd1);
          end else begin
            row_nxt = RW'(start_row);
          end
          if (32'(start_col) >= 32'(used_cols_nxt)) begin
            col_nxt = CW'(32'(used_cols_nxt) - 32'd1);
          end else begin
            col_nxt = CW'(start_col);
          end
          started_nxt   = 1'b1;
          ctl_nxt.visit = 1'b1;
          ctl_nxt.start = 1'b1;
        end
      end
      grwc_pkg::ACT_STEP: begin
        if (!started_r) begin
          ctl_nxt.status = grwc_pkg::ST_ORDER;
        end else if (done_now) begin
          ctl_nxt.status = grwc_pkg::ST_FINISHED;
        end else if (row_off || col_off) begin
          ctl_nxt.status = grwc_pkg::ST_OFF_GRID;
        end else begin
          row_nxt       = row_try;
          col_nxt       = col_try;
          moves_nxt     = moves_r + grwc_pkg::MOVE_W'(1);
          ctl_nxt.visit = 1'b1;
        end
      end
      default: begin
        ctl_nxt.status = grwc_pkg::ST_ORDER;
      end
    endcase
    ctl_nxt.started = started_nxt;
  end

  assign prod_nxt = UW'(32'(used_rows_nxt) * 32'(used_cols_nxt));
  assign addr_nxt = AW'(32'(row_nxt) * MAX_COLS + 32'(col_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      used_rows_r <= NRW'(grwc_pkg::MIN_DIM);
      used_cols_r <= NCW'(grwc_pkg::MIN_DIM);
      started_r   <= 1'b0;
      moves_r     <= '0;
    end else if (accept) begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      used_rows_r <= used_rows_nxt;
      used_cols_r <= used_cols_nxt;
      started_r   <= started_nxt;
      moves_r     <= moves_nxt;
    end
  end

endmodule

// ===== rtl/grid_random_walk_coverage_top.sv =====
// ----------------------------------------------------------------------------
// grid_random_walk_coverage_top
// random walk on a grid with per-cell visit counts and coverage tracking
// ----------------------------------------------------------------------------
// A bug walks a grid of grid_rows by grid_cols cells in king moves. A start
// item (action 0) latches the grid size, places the bug on the start cell and
// counts it; each step item (action 1) brings a direction 0..7 and moves the
// bug one cell, or is rejected if it would leave the grid. The walk is done
// once every cell has been visited or move_limit moves are taken; later steps
// report status finished. Every item gives exactly one result. The block
// takes one item per clock while in_stall is low: the walk stage decides
// the move and reads the cell count from the visit memory, the count stage
// bumps it and loads the result register.
// A back-to-back item that lands on the cell just written gets the new count
// through a bypass register. After reset the visit memory is swept to zero,
// one entry per clock, over all MAX_ROWS*MAX_COLS entries (2048 at the defaults);
// in_stall stays high during the sweep, config writes are taken as usual.
// Config is only to be written while no item is in flight.
// ----------------------------------------------------------------------------
module grid_random_walk_coverage_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  grwc_pkg::in_item_t              in_item,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output grwc_pkg::out_item_t             out_item,
  // config write port
  input  logic                            cfg_we,
  input  logic [grwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grwc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int UW    = $clog2(DEPTH + 1);

  // config registers
  logic [6:0]                  grid_rows_r;
  logic [5:0]                  grid_cols_r;
  logic [5:0]                  start_row_r;
  logic [4:0]                  start_col_r;
  logic [grwc_pkg::MOVE_W-1:0] move_limit_r;

  // handshake
  logic accept;
  logic out_free;
  logic s2_adv;
  logic clr_busy;

  // walk stage outputs
  logic [RW-1:0]               row_nxt;
  logic [CW-1:0]               col_nxt;
  logic [AW-1:0]               addr_nxt;
  logic [grwc_pkg::MOVE_W-1:0] moves_nxt;
  logic [UW-1:0]               prod_nxt;
  grwc_pkg::walk_ctl_t         ctl_nxt;

  // count stage registers
  logic                        s2_valid_r;
  grwc_pkg::walk_ctl_t         s2_ctl_r;
  logic [RW-1:0]               s2_row_r;
  logic [CW-1:0]               s2_col_r;
  logic [AW-1:0]               s2_addr_r;
  logic [grwc_pkg::MOVE_W-1:0] s2_moves_r;
  logic [UW-1:0]               s2_prod_r;

  // bypass of a count written on the same edge as its read
  logic                         byp_r;
  logic [grwc_pkg::VISIT_W-1:0] byp_data_r;

  logic [grwc_pkg::VISIT_W-1:0] rd_data;
  logic [grwc_pkg::VISIT_W-1:0] cnt_old;
  logic [grwc_pkg::VISIT_W-1:0] cnt_new;
  logic [UW-1:0]                unv_r;
  logic [UW-1:0]                unv_base;
  logic [UW-1:0]                unv_nxt;
  logic [UW-1:0]                unv_eff;
  logic                         done_s2;

  logic                         out_valid_r;
  grwc_pkg::out_item_t          out_item_r;

  // config writes, taken in any cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= grwc_pkg::GRID_ROWS_RST;
      grid_cols_r  <= grwc_pkg::GRID_COLS_RST;
      start_row_r  <= grwc_pkg::START_ROW_RST;
      start_col_r  <= grwc_pkg::START_COL_RST;
      move_limit_r <= grwc_pkg::MOVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        grwc_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_wdata[6:0];
        grwc_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_wdata[5:0];
        grwc_pkg::CFG_START_ROW:  start_row_r  <= cfg_wdata[5:0];
        grwc_pkg::CFG_START_COL:  start_col_r  <= cfg_wdata[4:0];
        grwc_pkg::CFG_MOVE_LIMIT: move_limit_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // result register frees when empty or being taken; count stage drains into it
  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_valid_r && out_free;
  assign in_stall = clr_busy || (s2_valid_r && !out_free);
  assign accept   = in_valid && !in_stall;

  // count stage: bump the visited cell and settle the unvisited counter
  assign cnt_old = byp_r ? byp_data_r : rd_data;

  always_comb begin
    cnt_new = cnt_old;
    if (s2_ctl_r.visit && (cnt_old != grwc_pkg::VISIT_MAX)) begin
      cnt_new = cnt_old + grwc_pkg::VISIT_W'(1);
    end
  end

  assign unv_base = s2_ctl_r.start ? s2_prod_r : unv_r;

  always_comb begin
    unv_nxt = unv_base;
    if (s2_ctl_r.visit && (cnt_old == '0) && (unv_base != '0)) begin
      unv_nxt = unv_base - UW'(1);
    end
  end

  assign done_s2 = s2_ctl_r.started &&
                   ((unv_nxt == '0) || (s2_moves_r >= move_limit_r));

  // the walk stage sees the counter as left by the item ahead of it
  assign unv_eff = s2_valid_r ? unv_nxt : unv_r;

  grwc_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW),
    .NRW      (NRW),
    .NCW      (NCW),
    .AW       (AW),
    .UW       (UW)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_item),
    .grid_rows  (grid_rows_r),
    .grid_cols  (grid_cols_r),
    .start_row  (start_row_r),
    .start_col  (start_col_r),
    .move_limit (move_limit_r),
    .unv_eff    (unv_eff),
    .row_nxt    (row_nxt),
    .col_nxt    (col_nxt),
    .addr_nxt   (addr_nxt),
    .moves_nxt  (moves_nxt),
    .prod_nxt   (prod_nxt),
    .ctl_nxt    (ctl_nxt)
  );

  grwc_visit_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_visit_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (s2_adv && s2_ctl_r.visit),
    .waddr    (s2_addr_r),
    .wdata    (cnt_new),
    .re       (accept),
    .raddr    (addr_nxt),
    .rdata    (rd_data),
    .clr_busy (clr_busy)
  );

  // count stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      unv_r      <= '0;
    end else begin
      if (accept) begin
        s2_valid_r <= 1'b1;
        // memory read on this edge misses the write of the item ahead
        byp_r      <= s2_adv && s2_ctl_r.visit && (s2_addr_r == addr_nxt);
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        unv_r <= unv_nxt;
      end
    end
  end

  // count stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_ctl_r   <= ctl_nxt;
      s2_row_r   <= row_nxt;
      s2_col_r   <= col_nxt;
      s2_addr_r  <= addr_nxt;
      s2_moves_r <= moves_nxt;
      s2_prod_r  <= prod_nxt;
      byp_data_r <= cnt_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_item_r.status          <= s2_ctl_r.status;
      out_item_r.bug_row         <= 6'(s2_row_r);
      out_item_r.bug_col         <= 5'(s2_col_r);
      out_item_r.cell_visits     <= cnt_new;
      out_item_r.move_count      <= s2_moves_r;
      out_item_r.cells_unvisited <= 12'(unv_nxt);
      out_item_r.walk_done       <= done_s2;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/grwc_checker.sv =====
// ----------------------------------------------------------------------------
// grwc_checker
// port-level checks of the grid random walk coverage block
// ----------------------------------------------------------------------------
`include "grid_random_walk_coverage_top_defines.svh"

module grwc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input grwc_pkg::out_item_t out_item
);

  // a stalled result stays offered and unchanged
  `GRWC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed or dropped")

  // the memory sweep keeps the input stalled right after reset
  `GRWC_ASSERT(a_sweep_stall, clk, rst_n, !$past(rst_n) |-> in_stall, "input not stalled after reset")

  // a result appears only after an accepted item has passed the count stage
  `GRWC_ASSERT(a_out_origin, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without an accepted item")

  // no result is offered during reset
  `GRWC_ASSERT_ALWAYS(a_rst_quiet, clk, !$past(rst_n) && !rst_n |=> !out_valid, "result offered in reset")

endmodule

bind grid_random_walk_coverage_top grwc_checker u_grwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
